@@ hdl/akrt_pkg.sv @@
package akrt_pkg;

  // fixed field widths
  localparam int unsigned KeyW     = 6;
  localparam int unsigned RawW     = 12;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned ScaleW   = 18;
  localparam int unsigned IdleW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SpanCfgW = 12;

  // scale divide: floor(255 * 65536 / span), saturated to 18 bits
  localparam int unsigned          QuotW          = 24;
  localparam logic [QuotW-1:0]     SCALE_DIVIDEND = 24'hFF0000;
  localparam logic [ScaleW-1:0]    SCALE_MAX      = 18'h3FFFF;
  localparam logic [LevelW-1:0]    LEVEL_MAX      = 8'd255;
  localparam logic [IdleW-1:0]     IDLE_MAX       = 8'd255;

  // mode codes
  localparam logic [ModeW-1:0] MODE_RAPID    = 2'd1;
  localparam logic [ModeW-1:0] MODE_STANDARD = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TOP  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_FLOOR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOTTOM_ZONE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STD_THRESH   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_SPAN     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_LIMIT   = 3'd6;

  // configuration reset values
  localparam logic [LevelW-1:0]   RST_RELEASE_TOP = 8'd10;
  localparam logic [LevelW-1:0]   RST_PRESS_FLOOR = 8'd10;
  localparam logic [LevelW-1:0]   RST_BOTTOM_ZONE = 8'd35;
  localparam logic [LevelW-1:0]   RST_HYSTERESIS  = 8'd10;
  localparam logic [LevelW-1:0]   RST_STD_THRESH  = 8'd100;
  localparam logic [SpanCfgW-1:0] RST_MIN_SPAN    = 12'd200;
  localparam logic [IdleW-1:0]    RST_IDLE_LIMIT  = 8'd200;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_DIV1   = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_DIV2   = 7'b0100000,
    ST_WB     = 7'b1000000
  } state_e;

endpackage

@@ hdl/akrt_store.sv @@
module akrt_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter logic [WIDTH-1:0] RST_VAL = '0,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  // entry storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry valid bits, an entry never written reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : RST_VAL;

endmodule

@@ hdl/akrt_div.sv @@
module akrt_div #(
  parameter int unsigned DW = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [akrt_pkg::ScaleW-1:0] scale_o
);
  import akrt_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   dvs_q;
  logic [DW-1:0]   rem_q;
  logic [QuotW-1:0] quo_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            fits;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[QuotW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= SCALE_DIVIDEND;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[QuotW-2:0], fits};
    end
  end

  assign done_o  = done_q;
  assign scale_o = (|quo_q[QuotW-1:ScaleW]) ? SCALE_MAX : quo_q[ScaleW-1:0];

endmodule

@@ hdl/analog_key_rapid_trigger.sv @@
// Per-key analog switch qualifier. Each input transaction carries one raw sample
// of one key; the block looks up that key's min, max, scale, stored level,
// held state and idle count in an on-chip table, updates them and returns one
// result transaction with the key, its stored level, its held state and its
// report bit. Items are processed one at a time; a sample needs at most two
// scale divides, one when min or max moves and one when the key releases
// near the top or recalibrates, each only when the span exceeds the minimum
// span. The divide is a one-bit-per-cycle restoring divider producing the
// 24-bit quotient. The next sample may be accepted while the previous result
// waits at the output. Table entries start at their reset values through
// per-key valid bits, so no clearing pass is needed. Configuration must be
// written through the cfg channel only while the block is idle; the block
// itself does not enforce this, and cfg_ready_o is always high.
module analog_key_rapid_trigger #(
  parameter int unsigned NUM_KEYS = 64,
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [akrt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [akrt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [akrt_pkg::KeyW-1:0]     key_index_i,
  input  logic [akrt_pkg::RawW-1:0]     raw_sample_i,
  input  logic [akrt_pkg::ModeW-1:0]    mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [akrt_pkg::KeyW-1:0]     key_out_o,
  output logic [akrt_pkg::LevelW-1:0]   level_o,
  output logic                          held_o,
  output logic                          report_o
);
  import akrt_pkg::*;

  localparam int unsigned AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned EW    = 2 * ADC_BITS + ScaleW + LevelW + 1 + IdleW;
  localparam int unsigned ProdW = ADC_BITS + ScaleW;
  localparam logic [EW-1:0] EntryRst = {{ADC_BITS{1'b1}}, {(EW - ADC_BITS){1'b0}}};

  // configuration registers
  logic [LevelW-1:0]   rel_top_q, press_floor_q, bottom_zone_q, hyst_q, std_thr_q;
  logic [SpanCfgW-1:0] min_span_q;
  logic [IdleW-1:0]    idle_limit_q;

  // sequencer and working registers
  state_e              st_q, st_d;
  logic [KeyW-1:0]     key_q;
  logic [ADC_BITS-1:0] raw_q;
  logic [ModeW-1:0]    mode_q;
  logic                oor_q;
  logic [ADC_BITS-1:0] min_q, max_q;
  logic [ScaleW-1:0]   scale_q;
  logic [LevelW-1:0]   prev_q, lvl_q;
  logic                pressed_q, report_q;
  logic [IdleW-1:0]    idle_q;
  logic [ProdW-1:0]    prod_q;

  // output register
  logic                out_valid_q;
  logic [KeyW-1:0]     key_out_q;
  logic [LevelW-1:0]   level_out_q;
  logic                held_out_q, report_out_q;

  // table and divider hookup
  logic                in_acc, out_free, key_oor;
  logic [EW-1:0]       rd_data;
  logic [ADC_BITS-1:0] rd_min, rd_max;
  logic [ScaleW-1:0]   rd_scale;
  logic [LevelW-1:0]   rd_level;
  logic                rd_pressed;
  logic [IdleW-1:0]    rd_idle;
  logic                wr_en;
  logic                div_start, div_done;
  logic [ADC_BITS-1:0] div_span;
  logic [ScaleW-1:0]   div_scale;

  // read-stage terms
  logic [ADC_BITS-1:0] min_n, max_n, span1;
  logic                changed, cond1;

  // decide-stage terms
  logic [ADC_BITS-1:0] span3, span2;
  logic                cond3, cond2;
  logic [LevelW-1:0]   lvl_c, lvl_n, bottom;
  logic [LevelW:0]     prev_p_hyst, lvl_p_hyst;
  logic                pressed_n, report_n, rescale3, recal;
  logic [IdleW-1:0]    idle_n;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign key_oor     = 32'(key_index_i) >= NUM_KEYS;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_top_q     <= RST_RELEASE_TOP;
      press_floor_q <= RST_PRESS_FLOOR;
      bottom_zone_q <= RST_BOTTOM_ZONE;
      hyst_q        <= RST_HYSTERESIS;
      std_thr_q     <= RST_STD_THRESH;
      min_span_q    <= RST_MIN_SPAN;
      idle_limit_q  <= RST_IDLE_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RELEASE_TOP: rel_top_q     <= cfg_data_i[LevelW-1:0];
        CFG_PRESS_FLOOR: press_floor_q <= cfg_data_i[LevelW-1:0];
        CFG_BOTTOM_ZONE: bottom_zone_q <= cfg_data_i[LevelW-1:0];
        CFG_HYSTERESIS:  hyst_q        <= cfg_data_i[LevelW-1:0];
        CFG_STD_THRESH:  std_thr_q     <= cfg_data_i[LevelW-1:0];
        CFG_MIN_SPAN:    min_span_q    <= cfg_data_i[SpanCfgW-1:0];
        CFG_IDLE_LIMIT:  idle_limit_q  <= cfg_data_i[IdleW-1:0];
        default: ;
      endcase
    end
  end

  // per-key state table
  akrt_store #(
    .DEPTH   (NUM_KEYS),
    .WIDTH   (EW),
    .RST_VAL (EntryRst)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (AW'(key_index_i)),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(key_q)),
    .wr_data_i ({min_q, max_q, scale_q, lvl_q, pressed_q, idle_q})
  );

  assign {rd_min, rd_max, rd_scale, rd_level, rd_pressed, rd_idle} = rd_data;

  // shared scale divider
  akrt_div #(
    .DW (ADC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (div_span),
    .done_o    (div_done),
    .scale_o   (div_scale)
  );

  // min/max tracking on the fetched entry
  always_comb begin
    max_n   = (raw_q > rd_max) ? raw_q : rd_max;
    min_n   = (raw_q < rd_min) ? raw_q : rd_min;
    changed = (raw_q > rd_max) || (raw_q < rd_min);
    span1   = max_n - min_n;
    cond1   = changed && (max_n > min_n) && (32'(span1) > 32'(min_span_q));
  end

  // level saturation and key state update
  always_comb begin
    lvl_c       = (|prod_q[ProdW-1:16+LevelW]) ? LEVEL_MAX : prod_q[16+LevelW-1:16];
    bottom      = LEVEL_MAX - bottom_zone_q;
    prev_p_hyst = {1'b0, prev_q} + {1'b0, hyst_q};
    lvl_p_hyst  = {1'b0, lvl_c} + {1'b0, hyst_q};
    lvl_n       = lvl_c;
    pressed_n   = pressed_q;
    report_n    = 1'b0;
    idle_n      = idle_q;
    rescale3    = 1'b0;
    if (mode_q == MODE_RAPID) begin
      if (pressed_q) begin
        idle_n = '0;
        if ((lvl_c < rel_top_q) && (lvl_c < prev_q)) begin
          pressed_n = 1'b0;
          rescale3  = 1'b1;
        end else if ((lvl_p_hyst < {1'b0, prev_q}) && (lvl_c < bottom)) begin
          pressed_n = 1'b0;
        end else if ((lvl_c >= bottom) || (lvl_c > prev_q)) begin
          report_n = 1'b1;
        end else begin
          report_n = 1'b1;
          lvl_n    = prev_q;
        end
      end else begin
        if (({1'b0, lvl_c} > prev_p_hyst) && (lvl_c > press_floor_q)) begin
          idle_n    = '0;
          pressed_n = 1'b1;
          report_n  = 1'b1;
        end else if (lvl_c > prev_q) begin
          lvl_n = prev_q;
        end else if (lvl_c == prev_q) begin
          if (idle_q != IDLE_MAX) begin
            idle_n = idle_q + 1'b1;
          end
        end else begin
          idle_n = '0;
        end
      end
    end else if (mode_q == MODE_STANDARD) begin
      report_n = lvl_c > std_thr_q;
    end
    recal = (idle_n > idle_limit_q) && !pressed_n;
    span3 = max_q - min_q;
    cond3 = (max_q > min_q) && (32'(span3) > 32'(min_span_q));
    span2 = max_q - raw_q;
    cond2 = (max_q > raw_q) && (32'(span2) > 32'(min_span_q));
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_span  = span1;
    if (st_q == ST_READ) begin
      div_start = cond1;
    end else if (st_q == ST_DECIDE) begin
      div_span  = rescale3 ? span3 : span2;
      div_start = (rescale3 && cond3) || (recal && cond2);
    end
  end

  assign wr_en = (st_q == ST_WB) && out_free && !oor_q;

  // sequencer next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d = key_oor ? ST_WB : ST_READ;
        end
      end
      ST_READ: begin
        st_d = cond1 ? ST_DIV1 : ST_MUL;
      end
      ST_DIV1: begin
        if (div_done) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        st_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        st_d = div_start ? ST_DIV2 : ST_WB;
      end
      ST_DIV2: begin
        if (div_done) begin
          st_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // working registers, no overlap between items so no forwarding needed
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_q  <= key_index_i;
          raw_q  <= ADC_BITS'(raw_sample_i);
          mode_q <= mode_i;
          oor_q  <= key_oor;
        end
      end
      ST_READ: begin
        min_q     <= min_n;
        max_q     <= max_n;
        scale_q   <= rd_scale;
        prev_q    <= rd_level;
        pressed_q <= rd_pressed;
        idle_q    <= rd_idle;
      end
      ST_DIV1: begin
        if (div_done) begin
          scale_q <= div_scale;
        end
      end
      ST_MUL: begin
        prod_q <= {{ScaleW{1'b0}}, raw_q - min_q} * {{ADC_BITS{1'b0}}, scale_q};
      end
      ST_DECIDE: begin
        lvl_q     <= lvl_n;
        pressed_q <= pressed_n;
        report_q  <= report_n;
        idle_q    <= recal ? '0 : idle_n;
        if (recal) begin
          min_q <= raw_q;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          scale_q <= div_scale;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((st_q == ST_WB) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == ST_WB) && out_free) begin
      key_out_q    <= key_q;
      level_out_q  <= oor_q ? '0 : lvl_q;
      held_out_q   <= !oor_q && pressed_q;
      report_out_q <= !oor_q && report_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = key_out_q;
  assign level_o     = level_out_q;
  assign held_o      = held_out_q;
  assign report_o    = report_out_q;

endmodule

@@ hdl/akrt_checker.sv @@
module akrt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [akrt_pkg::KeyW-1:0]   key_out_o,
  input logic [akrt_pkg::LevelW-1:0] level_o,
  input logic                        held_o,
  input logic                        report_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(key_out_o) && $stable(level_o)
      && $stable(held_o) && $stable(report_o))
    else $error("result payload changed while stalled");

  // one sample in flight: ready drops after each input transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second sample accepted while one is in flight");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a sample in flight");

endmodule

bind analog_key_rapid_trigger akrt_checker u_akrt_checker (.*);
